@@ hw/rtl/spq_pkg.sv @@
// Package for the stable priority queue: word types, entry type, codes and sequencer states.
`default_nettype none

package spq_pkg;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    localparam logic [1:0] STAT_INSERTED = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_REMOVED  = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    localparam int PRI_W = 8;
    localparam int PAY_W = 32;
    localparam int OCC_W = 5;

    typedef struct packed {
        logic             action;
        logic [PRI_W-1:0] new_priority;
        logic [PAY_W-1:0] new_payload;
    } req_word_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [PRI_W-1:0] head_priority;
        logic [PAY_W-1:0] head_payload;
        logic [OCC_W-1:0] occupancy;
    } rsp_word_t;

    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [PAY_W-1:0] payload;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_REM_RD,
        ST_REM_DATA,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/stable_priority_queue_core.sv @@
// Stable priority queue: circular entry memory with a sorted insert walked by one comparator.
//
//   channel | direction | handshake               | word
//   req     | in        | req_valid / req_ready   | spq_pkg::req_word_t
//   rsp     | out       | rsp_valid / rsp_ready   | spq_pkg::rsp_word_t
//
// Insert walks stored entries from the tail toward the head, one memory read and one priority
// compare per step, until the new entry lands behind an equal or lower priority or at the head.
// Remove reads the head entry and returns it; rejected full or empty items skip to the response.
// Reset clears count, head pointer and sequencer; memory contents need no reset.
// req_ready is high only in idle; a stalled rsp holds the next result in its pending stage.
`default_nettype none

module stable_priority_queue_core #(
    parameter int DEPTH = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_ready,
    input  spq_pkg::req_word_t  req,
    output logic                rsp_valid,
    input  wire                 rsp_ready,
    output spq_pkg::rsp_word_t  rsp
);
    import spq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t         mem [DEPTH];
    entry_t         rd_data_reg;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [AW-1:0]  head_reg, head_next;
    logic [CW-1:0]  idx_reg, idx_next;
    entry_t         new_reg, new_next;
    rsp_word_t      res_reg, res_next;
    logic           rsp_valid_reg, rsp_valid_next;
    rsp_word_t      rsp_reg, rsp_next;

    logic           mem_wr_en;
    logic [AW-1:0]  mem_wr_addr;
    entry_t         mem_wr_data;
    logic           mem_rd_en;
    logic [AW-1:0]  mem_rd_addr;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH))
            sum = sum - (CW+1)'(DEPTH);
        return sum[AW-1:0];
    endfunction

    function automatic logic [OCC_W-1:0] occ(input logic [CW-1:0] cnt);
        logic [CW+OCC_W-1:0] wide;
        wide = {{OCC_W{1'b0}}, cnt};
        return wide[OCC_W-1:0];
    endfunction

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= mem[mem_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        new_reg <= new_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        idx_next       = idx_reg;
        new_next       = new_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = head_reg;
        mem_wr_data    = new_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = head_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    new_next.pri     = req.new_priority;
                    new_next.payload = req.new_payload;
                    idx_next         = count_reg;
                    res_next         = '0;
                    res_next.occupancy = occ(count_reg);
                    if (req.action == ACT_INSERT)
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            res_next.status = STAT_FULL;
                            state_next      = ST_OUT;
                        end
                        else
                        begin
                            state_next = ST_INS_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = STAT_EMPTY;
                            state_next      = ST_OUT;
                        end
                        else
                        begin
                            state_next = ST_REM_RD;
                        end
                    end
                end
            end
            ST_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    mem_wr_en          = 1'b1;
                    mem_wr_addr        = head_reg;
                    mem_wr_data        = new_reg;
                    count_next         = count_reg + 1'b1;
                    res_next.status    = STAT_INSERTED;
                    res_next.occupancy = occ(count_reg + 1'b1);
                    state_next         = ST_OUT;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = phys(head_reg, idx_reg - 1'b1);
                    state_next  = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = phys(head_reg, idx_reg);
                if (rd_data_reg.pri > new_reg.pri)
                begin
                    mem_wr_data = rd_data_reg;
                    idx_next    = idx_reg - 1'b1;
                    state_next  = ST_INS_RD;
                end
                else
                begin
                    mem_wr_data        = new_reg;
                    count_next         = count_reg + 1'b1;
                    res_next.status    = STAT_INSERTED;
                    res_next.occupancy = occ(count_reg + 1'b1);
                    state_next         = ST_OUT;
                end
            end
            ST_REM_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = head_reg;
                state_next  = ST_REM_DATA;
            end
            ST_REM_DATA:
            begin
                head_next              = phys(head_reg, CW'(1));
                count_next             = count_reg - 1'b1;
                res_next.status        = STAT_REMOVED;
                res_next.head_priority = rd_data_reg.pri;
                res_next.head_payload  = rd_data_reg.payload;
                res_next.occupancy     = occ(count_reg - 1'b1);
                state_next             = ST_OUT;
            end
            ST_OUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(head_reg) < DEPTH)
        else $error("head pointer out of range");

    a_count_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> state_reg == ST_OUT)
        else $error("entry count changed outside item completion");

    a_read_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_rd_en |-> (state_reg == ST_INS_RD || state_reg == ST_REM_RD))
        else $error("memory read outside read states");

endmodule

`default_nettype wire
